// ----- src/imu_frame_parser_macros.svh -----
// Assertion helpers used by the checker of imu_frame_parser.
`ifndef IMU_FRAME_PARSER_MACROS_SVH
`define IMU_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define IMUFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imufp assertion failed");

// Next-cycle implication, ignored while reset is held.
`define IMUFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imufp assertion failed");

// Next-cycle implication that is also checked across reset.
`define IMUFP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("imufp assertion failed");

`endif

// ----- src/imufp_pkg.sv -----
package imufp_pkg;

    localparam int FRAME_LEN = 11;
    localparam int SUM_COUNT = 9;
    localparam int CHECK_POS = 9;
    localparam int FILL_W    = 4;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    localparam logic [7:0] RATE_ID_RST  = 8'h52;
    localparam logic [7:0] ANGLE_ID_RST = 8'h53;
    localparam logic [7:0] SYNC_RST     = 8'h55;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_ID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_ID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC     = 2'd2;

    localparam logic KIND_RATE  = 1'b0;
    localparam logic KIND_ANGLE = 1'b1;

    typedef struct packed {
        logic               valid;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_hit;

    typedef struct packed {
        logic               frame_kind;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic               last_result;
    } t_result;

endpackage

// ----- src/imufp_rx_if.sv -----
interface imufp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- src/imufp_res_if.sv -----
interface imufp_res_if;
    logic               valid;
    logic               ready;
    logic               frame_kind;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic               last_result;

    modport source (output valid, output frame_kind, output axis_x, output axis_y,
                    output axis_z, output last_result, input ready);
    modport sink   (input valid, input frame_kind, input axis_x, input axis_y,
                    input axis_z, input last_result, output ready);
endinterface

// ----- src/imu_frame_parser.sv -----
// IMU frame parser. Takes one serial byte per word on i_rx and runs two framers on it, angular
// rate and angle. A framer opens on its id byte, keeps up to 11 bytes and closes on the sync
// byte; if sync plus bytes 0..8 (mod 256) equals byte 9, one result word goes out with the
// frame kind and three signed little-endian 16-bit values. A byte that closes both frames gives
// the rate word first, then the angle word; last_result marks the final word of a byte.
// Throughput is one byte per clock while the queue has room; a byte that yields two words
// writes both into the queue at once. A 4-word output queue absorbs that: the byte in the
// input register is processed only while the queue has room for two words, so input stalls
// once three or more words wait. A byte goes through the input register, then the queue.
// The id and sync registers are written through i_cfg_*; the user must write them only while
// the block is idle, and the block itself does not enforce it.
module imu_frame_parser
    import imufp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    imufp_rx_if.sink             i_rx,
    imufp_res_if.source          o_res
);

    logic [7:0] r_rate_id;
    logic [7:0] r_angle_id;
    logic [7:0] r_sync;

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    t_result             r_q [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wp;
    logic [OQ_PTR_W-1:0] r_rp;
    logic [OQ_CNT_W-1:0] r_cnt;

    logic go;
    logic pop;
    t_hit rate_hit;
    t_hit angle_hit;
    logic h_rate;
    logic h_angle;
    t_result rate_res;
    t_result angle_res;
    logic [OQ_CNT_W-1:0] n_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_id  <= RATE_ID_RST;
            r_angle_id <= ANGLE_ID_RST;
            r_sync     <= SYNC_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RATE_ID:  r_rate_id  <= i_cfg_data;
                CFG_ANGLE_ID: r_angle_id <= i_cfg_data;
                CFG_SYNC:     r_sync     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // process a byte only when the queue has room for two words
    assign go         = r_in_valid && (r_cnt <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign i_rx.ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    imufp_framer u_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (go),
        .i_byte  (r_in_byte),
        .i_id    (r_rate_id),
        .i_sync  (r_sync),
        .o_hit   (rate_hit)
    );

    imufp_framer u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (go),
        .i_byte  (r_in_byte),
        .i_id    (r_angle_id),
        .i_sync  (r_sync),
        .o_hit   (angle_hit)
    );

    assign h_rate  = go && rate_hit.valid;
    assign h_angle = go && angle_hit.valid;
    assign n_push  = OQ_CNT_W'(h_rate) + OQ_CNT_W'(h_angle);
    assign pop     = (r_cnt != '0) && o_res.ready;

    always_comb begin
        rate_res.frame_kind   = KIND_RATE;
        rate_res.axis_x       = rate_hit.x;
        rate_res.axis_y       = rate_hit.y;
        rate_res.axis_z       = rate_hit.z;
        rate_res.last_result  = !h_angle;
        angle_res.frame_kind  = KIND_ANGLE;
        angle_res.axis_x      = angle_hit.x;
        angle_res.axis_y      = angle_hit.y;
        angle_res.axis_z      = angle_hit.z;
        angle_res.last_result = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (h_rate) begin
            r_q[r_wp] <= rate_res;
        end
        if (h_angle) begin
            r_q[h_rate ? OQ_PTR_W'(r_wp + 1'b1) : r_wp] <= angle_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= OQ_PTR_W'(r_wp + n_push);
            r_rp  <= OQ_PTR_W'(r_rp + OQ_PTR_W'(pop));
            r_cnt <= OQ_CNT_W'(r_cnt + n_push - OQ_CNT_W'(pop));
        end
    end

    assign o_res.valid       = (r_cnt != '0);
    assign o_res.frame_kind  = r_q[r_rp].frame_kind;
    assign o_res.axis_x      = r_q[r_rp].axis_x;
    assign o_res.axis_y      = r_q[r_rp].axis_y;
    assign o_res.axis_z      = r_q[r_rp].axis_z;
    assign o_res.last_result = r_q[r_rp].last_result;

endmodule

// ----- src/imufp_framer.sv -----
module imufp_framer
    import imufp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_id,
    input  logic [7:0] i_sync,
    output t_hit       o_hit
);

    logic              r_active;
    logic [FILL_W-1:0] r_fill;
    logic [7:0]        r_store [FRAME_LEN];

    logic              n_active;
    logic [FILL_W-1:0] n_fill;
    logic [7:0]        n_store [FRAME_LEN];

    logic              act_pre;
    logic [FILL_W-1:0] fill_pre;
    logic              wr;
    logic              close;
    logic [7:0]        sum;

    always_comb begin
        act_pre  = r_active;
        fill_pre = r_fill;
        // id byte (re)opens the frame
        if (i_byte == i_id) begin
            act_pre  = 1'b1;
            fill_pre = '0;
        end

        wr       = 1'b0;
        n_active = act_pre;
        n_fill   = fill_pre;
        if (act_pre) begin
            if (fill_pre < FILL_W'(FRAME_LEN)) begin
                wr     = 1'b1;
                n_fill = FILL_W'(fill_pre + 1'b1);
            end else begin
                // buffer full, no terminator: drop the frame
                n_active = 1'b0;
                n_fill   = '0;
            end
        end

        for (int i = 0; i < FRAME_LEN; i++) begin
            n_store[i] = (wr && fill_pre == FILL_W'(i)) ? i_byte : r_store[i];
        end

        close = n_active && (i_byte == i_sync);
        if (close) begin
            n_active = 1'b0;
        end

        sum = i_sync;
        for (int i = 0; i < SUM_COUNT; i++) begin
            sum = 8'(sum + n_store[i]);
        end

        o_hit.valid = close && (sum == n_store[CHECK_POS]);
        o_hit.x     = {n_store[2], n_store[1]};
        o_hit.y     = {n_store[4], n_store[3]};
        o_hit.z     = {n_store[6], n_store[5]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_fill   <= '0;
            for (int i = 0; i < FRAME_LEN; i++) begin
                r_store[i] <= '0;
            end
        end else if (i_step) begin
            r_active <= n_active;
            r_fill   <= n_fill;
            r_store  <= n_store;
        end
    end

endmodule

// ----- src/imufp_checker.sv -----
`include "imu_frame_parser_macros.svh"

module imufp_checker
    import imufp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input logic               i_res_kind,
    input logic signed [15:0] i_res_x,
    input logic               i_res_last
);

    // no word can be pending right after reset
    `IMUFP_ASSERT_NEXT_ALWAYS(a_idle_after_reset, i_clk, !i_rst_n, !i_res_valid)

    // only a rate word can be followed by a second word of the same byte
    `IMUFP_ASSERT_NOW(a_first_is_rate, i_clk, i_rst_n, i_res_valid && !i_res_last,
        i_res_kind == KIND_RATE)

    // the angle word of a two-word byte is queued right behind the rate word
    `IMUFP_ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n,
        i_res_valid && i_res_ready && !i_res_last,
        i_res_valid && (i_res_kind == KIND_ANGLE) && i_res_last)

    `IMUFP_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready,
        i_res_valid && $stable(i_res_x) && $stable(i_res_kind))

endmodule

bind imu_frame_parser imufp_checker u_imufp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_kind  (o_res.frame_kind),
    .i_res_x     (o_res.axis_x),
    .i_res_last  (o_res.last_result)
);
